// File: design/tcw_pkg.sv
package tcw_pkg;

  // Field widths fixed by the item format
  localparam int CURSOR_W = 11;
  localparam int ADDR_W   = 11;
  localparam int CELL_W   = 16;

  // Selector codes
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Control characters
  localparam logic [7:0] CODE_NUL = 8'd0;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_CR  = 8'd13;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PUT,
    OP_LF,
    OP_CR,
    OP_CLEAR,
    OP_READ
  } tcw_op_t;

  typedef struct packed {
    tcw_op_t           op;
    logic [7:0]        attr;
    logic [7:0]        ch;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
  } tcw_item_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_RDWAIT,
    B_COPY,
    B_BLANK
  } tcw_state_t;

endpackage

// File: design/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/tcw_front.sv
module tcw_front #(
  parameter int CELLS = 2000
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            func,
  input  logic [7:0]            char_code,
  input  logic [7:0]            attribute,
  input  logic [tcw_pkg::ADDR_W-1:0] cell_address,
  output logic                  q_valid,
  input  logic                  q_ready,
  output tcw_pkg::tcw_item_t    q_item
);
  import tcw_pkg::*;

  tcw_item_t  item_in;
  tcw_item_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  // Classify the incoming item
  always_comb begin
    item_in.attr    = attribute;
    item_in.ch      = char_code;
    item_in.addr    = cell_address;
    item_in.addr_ok = 32'(cell_address) < 32'(CELLS);
    unique case (func)
      FUNC_PUT: begin
        if (char_code == CODE_NUL) begin
          item_in.op = OP_NOP;
        end else if (char_code == CODE_LF) begin
          item_in.op = OP_LF;
        end else if (char_code == CODE_CR) begin
          item_in.op = OP_CR;
        end else begin
          item_in.op = OP_PUT;
        end
      end
      FUNC_CLEAR: item_in.op = OP_CLEAR;
      FUNC_READ:  item_in.op = OP_READ;
      default:    item_in.op = OP_NOP;
    endcase
  end

  // Two-entry queue toward the back end
  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

endmodule

// File: design/tcw_back.sv
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  tcw_pkg::tcw_item_t            q_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int LAST  = CELLS - COLUMNS;

  localparam logic [AW-1:0]  LAST_A  = AW'(LAST);
  localparam logic [AW-1:0]  COPY_END = AW'(LAST - 1);
  localparam logic [AW-1:0]  END_A   = AW'(CELLS - 1);
  localparam logic [AW-1:0]  COLS_A  = AW'(COLUMNS);
  localparam logic [CLW-1:0] COL_MAX = CLW'(COLUMNS - 1);

  tcw_state_t state, state_next;

  logic [AW-1:0]       cursor, cursor_next;
  logic [CLW-1:0]      col, col_next;
  logic [AW-1:0]       k, k_next;
  logic                rd_ok, rd_ok_next;
  logic                wr_en, wr_en_next;
  logic                wr_copy, wr_copy_next;
  logic [AW-1:0]       wr_addr, wr_addr_next;
  logic [CELL_W-1:0]   wr_data, wr_data_next;
  logic                out_valid_next;
  logic [CURSOR_W-1:0] cursor_position_next;
  logic [CELL_W-1:0]   cell_value_next;
  logic [AW-1:0]       rd_addr;
  logic [CELL_W-1:0]   rd_data;
  logic                pop;

  // Take a new item only when idle, the write slot is drained and the result slot frees
  assign pop     = (state == B_IDLE) && q_valid && !wr_en && (!out_valid || out_ready);
  assign q_ready = pop;

  // Screen memory: copy writes take the word read the cycle before
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_copy ? rd_data : wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop) begin
          unique case (q_item.op)
            OP_READ:  state_next = B_RDWAIT;
            OP_CLEAR: state_next = B_BLANK;
            OP_LF:    state_next = (cursor >= LAST_A) ? B_COPY : B_IDLE;
            OP_PUT:   state_next = (cursor == END_A) ? B_COPY : B_IDLE;
            default:  state_next = B_IDLE;
          endcase
        end
      end
      B_RDWAIT: state_next = B_IDLE;
      B_COPY:   state_next = (k == COPY_END) ? B_BLANK : B_COPY;
      B_BLANK:  state_next = (k == END_A) ? B_IDLE : B_BLANK;
      default:  state_next = B_IDLE;
    endcase
  end

  // Datapath and result slot
  always_comb begin
    cursor_next          = cursor;
    col_next             = col;
    k_next               = k;
    rd_ok_next           = rd_ok;
    rd_addr              = AW'(q_item.addr);
    wr_en_next           = 1'b0;
    wr_copy_next         = 1'b0;
    wr_addr_next         = wr_addr;
    wr_data_next         = wr_data;
    out_valid_next       = out_valid && !out_ready;
    cursor_position_next = cursor_position;
    cell_value_next      = cell_value;

    unique case (state)
      B_IDLE: begin
        if (pop) begin
          k_next = '0;
          unique case (q_item.op)
            OP_PUT: begin
              wr_en_next   = 1'b1;
              wr_addr_next = cursor;
              wr_data_next = {q_item.attr, q_item.ch};
              if (cursor == END_A) begin
                // last cell written: scroll, cursor to start of bottom row
                cursor_next = LAST_A;
                col_next    = '0;
              end else begin
                cursor_next    = cursor + AW'(1);
                col_next       = (col == COL_MAX) ? '0 : col + CLW'(1);
                out_valid_next = 1'b1;
              end
            end
            OP_LF: begin
              if (cursor < LAST_A) begin
                cursor_next    = cursor + COLS_A;
                out_valid_next = 1'b1;
              end
            end
            OP_CR: begin
              cursor_next    = cursor - AW'(col);
              col_next       = '0;
              out_valid_next = 1'b1;
            end
            OP_CLEAR: begin
              cursor_next = '0;
              col_next    = '0;
            end
            OP_READ: begin
              rd_ok_next = q_item.addr_ok;
            end
            default: begin
              out_valid_next = 1'b1;
            end
          endcase
          cursor_position_next = CURSOR_W'(cursor_next);
          cell_value_next      = '0;
        end
      end
      B_RDWAIT: begin
        out_valid_next       = 1'b1;
        cursor_position_next = CURSOR_W'(cursor);
        cell_value_next      = rd_ok ? rd_data : '0;
      end
      B_COPY: begin
        // read one row ahead, write back in the next cycle
        rd_addr      = k + COLS_A;
        wr_en_next   = 1'b1;
        wr_copy_next = 1'b1;
        wr_addr_next = k;
        k_next       = k + AW'(1);
      end
      B_BLANK: begin
        wr_en_next   = 1'b1;
        wr_addr_next = k;
        wr_data_next = BLANK_CELL;
        k_next       = k + AW'(1);
        if (k == END_A) begin
          out_valid_next       = 1'b1;
          cursor_position_next = CURSOR_W'(cursor);
          cell_value_next      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      cursor    <= '0;
      col       <= '0;
      wr_en     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cursor    <= cursor_next;
      col       <= col_next;
      wr_en     <= wr_en_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k               <= k_next;
    rd_ok           <= rd_ok_next;
    wr_copy         <= wr_copy_next;
    wr_addr         <= wr_addr_next;
    wr_data         <= wr_data_next;
    cursor_position <= cursor_position_next;
    cell_value      <= cell_value_next;
  end

endmodule

// File: design/text_console_cell_writer_top.sv
// Text console cell writer: a COLUMNS x ROWS screen of 16-bit cells
// (attribute high byte, character low byte) and a cursor.
// Input channel (in_valid/in_ready): func selects put character, clear
// screen or read cell; char_code, attribute and cell_address go with it.
// Output channel (out_valid/out_ready): one result item per input item,
// the cursor after the item and the cell read (zero for other items).
// Accepted items land in a two-entry queue; the back end executes them.
// CR, no-op and LF without scroll can issue every cycle while out_ready
// is high. A put or a read holds off the next item: a put holds the
// single memory write port the cycle after it issues, and a read waits
// on the registered memory read.
// Scrolling (LF on the bottom row, or a put into the last cell) copies
// one cell per cycle and then blanks the bottom row; clear screen blanks
// one cell per cycle.
// Reset clears the cursor to 0 and empties the queue and output; screen
// contents are undefined until written or cleared.
// When out_ready is low the result holds and the queue keeps filling;
// in_ready drops once both queue entries are taken.
module text_console_cell_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func,
  input  logic [7:0]                    char_code,
  input  logic [7:0]                    attribute,
  input  logic [tcw_pkg::ADDR_W-1:0]    cell_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value
);
  import tcw_pkg::*;

  logic      q_valid;
  logic      q_ready;
  tcw_item_t q_item;

  tcw_front #(
    .CELLS (COLUMNS * ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .char_code    (char_code),
    .attribute    (attribute),
    .cell_address (cell_address),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_position (cursor_position),
    .cell_value      (cell_value)
  );

endmodule

// File: design/tcw_checker.sv
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  input logic [tcw_pkg::CELL_W-1:0]    cell_value
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  // Reported cursor always lies on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(cursor_position) < 32'(CELLS)))
    else $error("cursor_position beyond last cell");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(cursor_position) && $stable(cell_value)))
    else $error("result changed while stalled");

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // Reset leaves the queue empty and open
  a_reset_in: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready right after reset");

endmodule

bind text_console_cell_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .cursor_position (cursor_position),
  .cell_value      (cell_value)
);

// File: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int LAST_ROW  = COLUMNS * (ROWS - 1);
  localparam int N_ITEMS   = 1650;
  localparam int HOLD_AT   = 40;
  localparam int HOLD_LEN  = 80;
  localparam int TAIL      = 20;
  localparam int LIMIT     = 10_000_000;

  // func code the block leaves unused
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        func;
    logic [7:0]        ch;
    logic [7:0]        attr;
    logic [ADDR_W-1:0] addr;
    bit                drain;   // hold back until all results are in
  } console_cmd_t;

  typedef struct {
    logic [CURSOR_W-1:0] cursor;
    logic [CELL_W-1:0]   value;
  } console_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = '0;
  logic [7:0] char_code = '0;
  logic [7:0] attribute = '0;
  logic [ADDR_W-1:0] cell_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CURSOR_W-1:0] cursor_position;
  logic [CELL_W-1:0] cell_value;

  console_cmd_t cmd_q[$];
  console_res_t cursor_value_q[$];

  // shadow of the screen and cursor
  logic [CELL_W-1:0]   screen_shadow [0:CELLS-1];
  logic [CURSOR_W-1:0] cursor_shadow = '0;

  int n_total;
  int n_acc = 0;
  int n_res = 0;
  int n_err = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_scrolls = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  text_console_cell_writer_top #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .char_code(char_code),
    .attribute(attribute),
    .cell_address(cell_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cursor_position(cursor_position),
    .cell_value(cell_value)
  );

  always #6 clk = ~clk;

  function automatic void queue_cmd(logic [1:0] f, logic [7:0] ch, logic [7:0] at,
                                    logic [ADDR_W-1:0] ad, bit drain = 1'b0);
    console_cmd_t c;
    c.func = f;
    c.ch = ch;
    c.attr = at;
    c.addr = ad;
    c.drain = drain;
    cmd_q.push_back(c);
  endfunction

  // move every row up one and blank the bottom row
  task automatic scroll_shadow();
    for (int i = 0; i < LAST_ROW; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
    for (int i = LAST_ROW; i < CELLS; i++) screen_shadow[i] = BLANK_CELL;
    n_scrolls++;
  endtask

  // expected cursor and read value for one item; updates the shadow
  task automatic console_predict(input console_cmd_t c, output console_res_t r);
    logic [CELL_W-1:0] val;
    val = '0;
    if (cursor_shadow >= CELLS) cursor_shadow = CURSOR_W'(LAST_ROW);
    case (c.func)
      FUNC_PUT: begin
        if (c.ch == CODE_LF) begin
          if (cursor_shadow >= LAST_ROW) scroll_shadow();
          else cursor_shadow = cursor_shadow + CURSOR_W'(COLUMNS);
        end else if (c.ch == CODE_CR) begin
          cursor_shadow = cursor_shadow - CURSOR_W'(cursor_shadow % COLUMNS);
        end else if (c.ch != CODE_NUL) begin
          screen_shadow[cursor_shadow] = {c.attr, c.ch};
          cursor_shadow = cursor_shadow + CURSOR_W'(1);
          if (cursor_shadow >= CELLS) begin
            scroll_shadow();
            cursor_shadow = CURSOR_W'(LAST_ROW);
          end
        end
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_shadow[i] = BLANK_CELL;
        cursor_shadow = '0;
        n_clears++;
      end
      FUNC_READ: begin
        if (c.addr < CELLS) val = screen_shadow[c.addr];
        n_reads++;
      end
      default: ;
    endcase
    r.cursor = cursor_shadow;
    r.value = val;
  endtask

  function automatic int send_idle_pct();
    int ph;
    ph = (n_acc * 3) / n_total;
    return (ph == 0) ? 36 : (ph == 1) ? 64 : 0;
  endfunction

  function automatic int recv_idle_pct();
    int ph;
    ph = (n_acc * 3) / n_total;
    return (ph == 0) ? 64 : (ph == 1) ? 36 : 0;
  endfunction

  // driver: predict on accept, then offer the next item or idle
  always @(posedge clk) begin
    console_cmd_t cur;
    console_res_t r;
    bit taken;
    bit drained;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        cur.func = func;
        cur.ch = char_code;
        cur.attr = attribute;
        cur.addr = cell_address;
        cur.drain = 1'b0;
        console_predict(cur, r);
        cursor_value_q.push_back(r);
        n_acc <= n_acc + 1;
      end
      if (!in_valid || taken) begin
        drained = !taken && (n_acc == n_res);
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct() &&
            (!cmd_q[0].drain || drained)) begin
          cur = cmd_q.pop_front();
          func <= cur.func;
          char_code <= cur.ch;
          attribute <= cur.attr;
          cell_address <= cur.addr;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_acc == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    console_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_res <= n_res + 1;
        if (cursor_value_q.size() == 0) begin
          if (n_err < 10)
            $display("unexpected result: cursor %0d value %h", cursor_position, cell_value);
          n_err++;
        end else begin
          e = cursor_value_q.pop_front();
          if (e.cursor !== cursor_position || e.value !== cell_value) begin
            if (n_err < 10)
              $display("mismatch at result %0d: cursor exp %0d got %0d, value exp %h got %h",
                       n_res, e.cursor, cursor_position, e.value, cell_value);
            n_err++;
          end
        end
      end
      out_ready <= (hold_left != 0) ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int len;
    int sel;
    logic [7:0] ch;
    logic [7:0] at;

    // directed: cell 0 is written before any read so no unwritten cell is read
    queue_cmd(FUNC_PUT, 8'h41, 8'h1f, 11'd0);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ, 8'hff, 8'hff, 11'h7ff);
    queue_cmd(FUNC_UNUSED, 8'hff, 8'hff, 11'h7ff);
    queue_cmd(FUNC_CLEAR, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd1999);
    queue_cmd(FUNC_PUT, CODE_NUL, 8'hff, 11'd0);
    queue_cmd(FUNC_PUT, 8'hff, 8'hff, 11'h7ff);
    queue_cmd(FUNC_PUT, 8'h01, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT, CODE_CR, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT, CODE_LF, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT, 8'h5a, 8'h80, 11'd0);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd80);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd2000);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd1);
    queue_cmd(FUNC_UNUSED, 8'h00, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT, CODE_LF, 8'h00, 11'd0);
    queue_cmd(FUNC_PUT, CODE_CR, 8'h00, 11'd0);
    queue_cmd(FUNC_READ, 8'h00, 8'h00, 11'd160, 1'b1);

    // random: mostly text lines with line endings, plus reads, clears and noise
    while (cmd_q.size() < N_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 24);
        at = 8'($urandom_range(0, 255));
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) begin
            do ch = 8'($urandom_range(1, 255)); while (ch == CODE_LF || ch == CODE_CR);
          end else begin
            ch = 8'($urandom_range(32, 126));
          end
          queue_cmd(FUNC_PUT, ch, at, ADDR_W'($urandom_range(0, 2047)));
          if ($urandom_range(0, 9) == 0)
            queue_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      ADDR_W'($urandom_range(0, 2047)));
        end
        sel = $urandom_range(0, 9);
        if (sel <= 5 || sel == 8)
          queue_cmd(FUNC_PUT, CODE_CR, at, ADDR_W'($urandom_range(0, 2047)));
        if (sel <= 7) queue_cmd(FUNC_PUT, CODE_LF, at, ADDR_W'($urandom_range(0, 2047)));
      end else if (sel < 85) begin
        queue_cmd(FUNC_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  ADDR_W'($urandom_range(0, 2047)));
      end else if (sel < 91) begin
        queue_cmd(FUNC_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  ADDR_W'($urandom_range(0, 2047)));
      end else if (sel < 94) begin
        queue_cmd(FUNC_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  ADDR_W'($urandom_range(0, 2047)));
      end else begin
        case ($urandom_range(0, 3))
          0: ch = CODE_NUL;
          1: ch = CODE_LF;
          2: ch = CODE_CR;
          default: ch = 8'($urandom_range(0, 255));
        endcase
        queue_cmd(FUNC_PUT, ch, 8'($urandom_range(0, 255)), ADDR_W'($urandom_range(0, 2047)));
      end
    end
    n_total = cmd_q.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // checked away from the active edge so the driver and monitor have settled
    while (cmd_q.size() != 0 || in_valid || n_res != n_acc) @(negedge clk);
    repeat (TAIL) @(posedge clk);

    $display("%0d items: %0d reads, %0d clears, %0d scrolls, %0d results checked",
             n_acc, n_reads, n_clears, n_scrolls, n_res);
    $display("mismatches or stray results: %0d, left waiting: %0d", n_err,
             cursor_value_q.size());
    if (n_err == 0 && cursor_value_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
